/* design/ccs_pkg.sv */
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the calendar clock event scheduler
// Item codes, event entry layout, calendar limits and controller interface.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int unsigned EVENT_SLOTS_DEF = 32;
  localparam int unsigned LINE_COUNT      = 8;

  // item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_SET   = 2'd2;

  // event actions
  localparam logic [1:0] ACT_EMPTY = 2'd0;
  localparam logic [1:0] ACT_ON    = 2'd1;
  localparam logic [1:0] ACT_OFF   = 2'd2;

  // calendar limits
  localparam logic [6:0] SEC_WRAP   = 7'd60;
  localparam logic [6:0] MIN_WRAP   = 7'd60;
  localparam logic [5:0] HOUR_WRAP  = 6'd24;
  localparam logic [5:0] DAY_OVER   = 6'd32;
  localparam logic [5:0] DAY_31     = 6'd31;
  localparam logic [5:0] DAY_30     = 6'd30;
  localparam logic [5:0] DAY_29     = 6'd29;
  localparam logic [3:0] MONTH_OVER = 4'd13;
  localparam logic [3:0] MON_FEB    = 4'd2;
  localparam logic [3:0] MON_APR    = 4'd4;
  localparam logic [3:0] MON_JUN    = 4'd6;
  localparam logic [3:0] MON_SEP    = 4'd9;
  localparam logic [3:0] MON_NOV    = 4'd11;

  localparam logic [5:0]  SEC_RESET   = 6'd0;
  localparam logic [5:0]  MIN_RESET   = 6'd0;
  localparam logic [4:0]  HOUR_RESET  = 5'd0;
  localparam logic [4:0]  DATE_RESET  = 5'd1;
  localparam logic [3:0]  MONTH_RESET = 4'd1;
  localparam logic [15:0] YEAR_RESET  = 16'd2000;
  localparam logic [7:0]  LINES_RESET = 8'hFF;

  // y is a multiple of 25 iff y * inv(25) mod 2^16 <= floor(65535 / 25)
  localparam logic [15:0] INV25       = 16'd23593;
  localparam logic [15:0] DIV25_LIMIT = 16'd2621;

  typedef struct packed {
    logic [2:0] device;
    logic [1:0] action;
    logic [4:0] hour;
    logic [5:0] minute;
  } ev_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take;    // item transfer this cycle
    logic scan;    // read the next event slot
    logic finish;  // load the tick result
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic out_free;
  } sts_t;

  // Gregorian rule: centuries leap only when divisible by 400 (= 25 * 16)
  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] prod;
    logic        div25;
    prod  = 16'(y * INV25);
    div25 = (prod <= DIV25_LIMIT);
    return div25 ? (y[3:0] == 4'd0) : (y[1:0] == 2'd0);
  endfunction

endpackage

/* design/ccs_ram.sv */
// ----------------------------------------------------------------------------
// ccs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ccs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/ccs_ctrl.sv */
// ----------------------------------------------------------------------------
// ccs_ctrl: item sequencer
// Takes items, walks the event table after a tick and releases the result.
// ----------------------------------------------------------------------------
module ccs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ccs_pkg::sts_t sts,
  output ccs_pkg::cmd_t cmd
);
  import ccs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && sts.out_free && sts.is_tick) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = !sts.out_free;
        cmd.take = in_valid && sts.out_free;
      end
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_DRAIN:  cmd        = '0;
      ST_FINISH: cmd.finish = 1'b1;
      default:   cmd        = '0;
    endcase
  end

endmodule

/* design/ccs_dp.sv */
// ----------------------------------------------------------------------------
// ccs_dp: calendar counters, event table and output register
// Advances the time, stores event slots and applies matching slots to lines.
// ----------------------------------------------------------------------------
module ccs_dp #(
  parameter int unsigned EVENT_SLOTS = ccs_pkg::EVENT_SLOTS_DEF,
  localparam int unsigned AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  ccs_pkg::cmd_t cmd,
  output ccs_pkg::sts_t sts,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_wr_data,
  input  logic [1:0]    kind,
  input  logic [4:0]    slot,
  input  logic [2:0]    device,
  input  logic [1:0]    action,
  input  logic [5:0]    second,
  input  logic [5:0]    minute,
  input  logic [4:0]    hour,
  input  logic [4:0]    date,
  input  logic [3:0]    month,
  input  logic [15:0]   year,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    drive_out,
  output logic [5:0]    cur_second,
  output logic [5:0]    cur_minute,
  output logic [4:0]    cur_hour,
  output logic [4:0]    cur_date,
  output logic [3:0]    cur_month,
  output logic [15:0]   cur_year
);
  import ccs_pkg::*;

  logic [2:0]  line_offset;
  logic [5:0]  sec_count, sec_next;
  logic [5:0]  min_count, min_next;
  logic [4:0]  hour_count, hour_next;
  logic [4:0]  day_of_month, day_next;
  logic [3:0]  month_count, month_next;
  logic [15:0] year_count, year_next;
  logic [7:0]  drive_lines, drive_lines_next;

  logic [EVENT_SLOTS-1:0] slot_valid;
  logic [AW-1:0]          scan_ptr;
  logic                   rd_pend;
  logic                   ent_valid;
  logic [15:0]            rd_data;

  logic [8:0]    slot_ext;
  logic          slot_in_range;
  logic [AW-1:0] waddr;
  logic          ram_we;
  ev_entry_t     wr_entry;
  ev_entry_t     entry;

  logic [6:0]  sec_inc;
  logic [6:0]  min_inc;
  logic [5:0]  hour_inc;
  logic [5:0]  day_inc;
  logic [3:0]  month_inc;
  logic        new_month;
  logic [5:0]  adv_sec;
  logic [5:0]  adv_min;
  logic [4:0]  adv_hour;
  logic        day_roll;
  logic [4:0]  adv_day;
  logic [3:0]  adv_month;
  logic [15:0] adv_year;

  logic        is_tick;
  logic        hit;
  logic [3:0]  line_sum;
  logic        out_load;

  // ---- event table ----
  assign slot_ext      = 9'(slot);
  assign slot_in_range = (slot_ext < 9'(EVENT_SLOTS));
  assign waddr         = slot_ext[AW-1:0];
  assign ram_we        = cmd.take && (kind == KIND_EVENT) && slot_in_range;
  assign wr_entry      = '{device: device, action: action, hour: hour, minute: minute};

  ccs_ram #(
    .WIDTH ($bits(ev_entry_t)),
    .DEPTH (EVENT_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wr_entry),
    .re    (cmd.scan),
    .raddr (scan_ptr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      scan_ptr   <= '0;
      rd_pend    <= 1'b0;
      ent_valid  <= 1'b0;
    end else begin
      if (ram_we) slot_valid[waddr] <= 1'b1;
      if (cmd.take) begin
        scan_ptr <= '0;
      end else if (cmd.scan) begin
        scan_ptr <= AW'(scan_ptr + 1'b1);
      end
      rd_pend   <= cmd.scan;
      ent_valid <= slot_valid[scan_ptr];
    end
  end

  assign sts.scan_last = (scan_ptr == AW'(EVENT_SLOTS - 1));

  // ---- calendar advance ----
  assign sec_inc   = 7'(sec_count) + 7'd1;
  assign min_inc   = 7'(min_count) + 7'd1;
  assign hour_inc  = 6'(hour_count) + 6'd1;
  assign day_inc   = 6'(day_of_month) + 6'd1;
  assign month_inc = 4'(month_count + 4'd1);

  always_comb begin
    adv_sec  = sec_inc[5:0];
    adv_min  = min_count;
    adv_hour = hour_count;
    day_roll = 1'b0;
    if (sec_inc == SEC_WRAP) begin
      adv_sec = '0;
      adv_min = min_inc[5:0];
      if (min_inc == MIN_WRAP) begin
        adv_min  = '0;
        adv_hour = hour_inc[4:0];
        if (hour_inc == HOUR_WRAP) begin
          adv_hour = '0;
          day_roll = 1'b1;
        end
      end
    end
  end

  always_comb begin
    new_month = 1'b0;
    if (day_inc == DAY_OVER) begin
      new_month = 1'b1;
    end else if (day_inc == DAY_31) begin
      new_month = (month_count == MON_APR) || (month_count == MON_JUN) ||
                  (month_count == MON_SEP) || (month_count == MON_NOV);
    end else if (day_inc == DAY_30) begin
      new_month = (month_count == MON_FEB);
    end else if (day_inc == DAY_29) begin
      new_month = (month_count == MON_FEB) && !is_leap(year_count);
    end
    adv_day   = new_month ? DATE_RESET : day_inc[4:0];
    adv_month = new_month ? month_inc : month_count;
    adv_year  = year_count;
    // month thirteen rolls into the next year
    if (adv_month == MONTH_OVER) begin
      adv_month = MONTH_RESET;
      adv_year  = 16'(year_count + 16'd1);
    end
  end

  assign is_tick = (kind == KIND_TICK);

  always_comb begin
    sec_next   = sec_count;
    min_next   = min_count;
    hour_next  = hour_count;
    day_next   = day_of_month;
    month_next = month_count;
    year_next  = year_count;
    if (cmd.take && is_tick) begin
      sec_next  = adv_sec;
      min_next  = adv_min;
      hour_next = adv_hour;
      if (day_roll) begin
        day_next   = adv_day;
        month_next = adv_month;
        year_next  = adv_year;
      end
    end else if (cmd.take && (kind == KIND_SET)) begin
      sec_next   = second;
      min_next   = minute;
      hour_next  = hour;
      day_next   = date;
      month_next = month;
      year_next  = year;
    end
  end

  // ---- event apply, one slot per cycle ----
  assign entry    = ent_valid ? ev_entry_t'(rd_data) : '0;
  assign line_sum = 4'(entry.device) + 4'(line_offset);
  assign hit      = rd_pend && (entry.hour == hour_count) && (entry.minute == min_count) &&
                    (line_sum < 4'(LINE_COUNT));

  always_comb begin
    drive_lines_next = drive_lines;
    if (hit) begin
      case (entry.action)
        ACT_ON:  drive_lines_next[line_sum[2:0]] = 1'b0;
        ACT_OFF: drive_lines_next[line_sum[2:0]] = 1'b1;
        default: drive_lines_next = drive_lines;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_offset  <= '0;
      sec_count    <= SEC_RESET;
      min_count    <= MIN_RESET;
      hour_count   <= HOUR_RESET;
      day_of_month <= DATE_RESET;
      month_count  <= MONTH_RESET;
      year_count   <= YEAR_RESET;
      drive_lines  <= LINES_RESET;
    end else begin
      if (cfg_wr_en) line_offset <= cfg_wr_data;
      sec_count    <= sec_next;
      min_count    <= min_next;
      hour_count   <= hour_next;
      day_of_month <= day_next;
      month_count  <= month_next;
      year_count   <= year_next;
      drive_lines  <= drive_lines_next;
    end
  end

  // ---- result register ----
  assign out_load     = (cmd.take && !is_tick) || cmd.finish;
  assign sts.is_tick  = is_tick;
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_out  <= drive_lines;
      cur_second <= sec_next;
      cur_minute <= min_next;
      cur_hour   <= hour_next;
      cur_date   <= day_next;
      cur_month  <= month_next;
      cur_year   <= year_next;
    end
  end

endmodule

/* design/calendar_clock_event_scheduler.sv */
// ----------------------------------------------------------------------------
// calendar_clock_event_scheduler: calendar clock with timed line switching
// Keeps the time and date, and switches output lines from an event table.
// ----------------------------------------------------------------------------
// A tick item advances the clock by one second and then walks the event table
// one slot per cycle through the single read port of the slot RAM; after the
// last slot a drain state and a finish state follow, and the finish state
// loads the tick result. Event writes, time sets and unused kinds load their
// result at the transfer edge. One item is in work at a time; the input
// is taken while the result register is empty or being drained. Every slot
// reads as empty after reset with no clearing pass, since each slot carries a
// valid flag. line_offset may be written only while the block is idle.
module calendar_clock_event_scheduler #(
  parameter int unsigned EVENT_SLOTS = ccs_pkg::EVENT_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [4:0]  slot,
  input  logic [2:0]  device,
  input  logic [1:0]  action,
  input  logic [5:0]  second,
  input  logic [5:0]  minute,
  input  logic [4:0]  hour,
  input  logic [4:0]  date,
  input  logic [3:0]  month,
  input  logic [15:0] year,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  drive_out,
  output logic [5:0]  cur_second,
  output logic [5:0]  cur_minute,
  output logic [4:0]  cur_hour,
  output logic [4:0]  cur_date,
  output logic [3:0]  cur_month,
  output logic [15:0] cur_year
);
  import ccs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ccs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccs_dp #(
    .EVENT_SLOTS (EVENT_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .kind        (kind),
    .slot        (slot),
    .device      (device),
    .action      (action),
    .second      (second),
    .minute      (minute),
    .hour        (hour),
    .date        (date),
    .month       (month),
    .year        (year),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_out   (drive_out),
    .cur_second  (cur_second),
    .cur_minute  (cur_minute),
    .cur_hour    (cur_hour),
    .cur_date    (cur_date),
    .cur_month   (cur_month),
    .cur_year    (cur_year)
  );

endmodule

/* design/ccs_chk.sv */
// ----------------------------------------------------------------------------
// ccs_chk: port-level checks for the calendar clock event scheduler
// Watches handshakes and result timing on the top-level ports.
// ----------------------------------------------------------------------------
module ccs_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  kind,
  input logic [5:0]  second,
  input logic [15:0] year,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  drive_out,
  input logic [5:0]  cur_second,
  input logic [15:0] cur_year
);
  import ccs_pkg::*;

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(drive_out) && $stable(cur_second) && $stable(cur_year))
    else $error("stalled result changed");

  // no new transfer while a result is held back
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  // a time set shows up as the result right after its transfer
  a_set_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (kind == KIND_SET) |=>
      out_valid && (cur_second == $past(second)) && (cur_year == $past(year)))
    else $error("time set result wrong or late");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind calendar_clock_event_scheduler ccs_chk u_ccs_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .kind       (kind),
  .second     (second),
  .year       (year),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .drive_out  (drive_out),
  .cur_second (cur_second),
  .cur_year   (cur_year)
);
